### rtl/dtsfh_pkg.sv
// Shared types, constants and helper functions for the DTS frame header parser.
// No dependencies; imported by every module in rtl/.
package dtsfh_pkg;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int CNT_W    = 15;
    localparam int WIN_W    = 60;
    localparam int RATE_W   = 18;
    localparam int LAYOUT_W = 4;
    localparam int REL_W    = 2;
    localparam int NB_W     = 7;
    localparam int FS_W     = 14;
    localparam int SF_W     = 4;
    localparam int SCNT_W   = 13;
    localparam int CORE_W   = 15;
    localparam int HD_W     = 21;
    localparam int TOTAL_W  = 21;
    localparam int SPDIF_W  = 4;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 104;

    // first byte of a candidate header
    localparam logic [7:0] FIRST_BE16 = 8'h7f;
    localparam logic [7:0] FIRST_LE16 = 8'hfe;
    localparam logic [7:0] FIRST_BE14 = 8'h1f;
    localparam logic [7:0] FIRST_LE14 = 8'hff;

    localparam logic [15:0] SYNC16_W0 = 16'h7ffe;
    localparam logic [15:0] SYNC16_W1 = 16'h8001;
    localparam logic [15:0] SYNC14_W0 = 16'h1fff;
    localparam logic [15:0] SYNC14_W1 = 16'he800;
    localparam logic [11:0] SYNC14_W2 = 12'h07f;
    localparam logic [15:0] EXT_SYNC_W0 = 16'h6458;
    localparam logic [15:0] EXT_SYNC_W1 = 16'h2025;

    localparam logic [13:0] LAST_WORD16 = 14'd5;
    localparam logic [13:0] LAST_WORD14 = 14'd6;
    localparam logic [13:0] EXT_LAST_WORD = 14'd4;
    localparam logic [NB_W-1:0] MIN_BLOCKS = 7'd5;
    localparam logic [5:0] MAX_LAYOUT = 6'd9;
    localparam logic [1:0] LFF_BAD = 2'd3;

    localparam logic [LAYOUT_W-1:0] LAYOUT_SUMDIFF = 4'd3;
    localparam logic [LAYOUT_W-1:0] LAYOUT_DOLBY   = 4'd4;
    localparam logic [REL_W-1:0] REL_NONE    = 2'd0;
    localparam logic [REL_W-1:0] REL_SUMDIFF = 2'd1;
    localparam logic [REL_W-1:0] REL_DOLBY   = 2'd2;

    localparam logic [SCNT_W-1:0] CNT_512  = 13'd512;
    localparam logic [SCNT_W-1:0] CNT_1024 = 13'd1024;
    localparam logic [SCNT_W-1:0] CNT_2048 = 13'd2048;
    localparam logic [SPDIF_W-1:0] SPDIF_NONE = 4'd0;
    localparam logic [SPDIF_W-1:0] SPDIF_512  = 4'd11;
    localparam logic [SPDIF_W-1:0] SPDIF_1024 = 4'd12;
    localparam logic [SPDIF_W-1:0] SPDIF_2048 = 4'd13;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEAD,
        PH_SKIP,
        PH_EXT
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              start_req;
    } in_item_t;

    typedef struct packed {
        logic                valid_res;
        logic                little_endian;
        logic                fourteen_bit;
        logic [RATE_W-1:0]   sample_rate;
        logic [LAYOUT_W-1:0] channel_layout;
        logic [REL_W-1:0]    channel_relation;
        logic                lfe_present;
        logic [SCNT_W-1:0]   sample_count;
        logic [CORE_W-1:0]   core_size;
        logic [HD_W-1:0]     hd_size;
        logic [TOTAL_W-1:0]  total_frame_size;
        logic [SPDIF_W-1:0]  spdif_type;
    } result_t;

    typedef struct packed {
        logic [SF_W-1:0]     sf;
        logic [LAYOUT_W-1:0] am;
        logic                lfe;
        logic [NB_W-1:0]     nb;
        logic [FS_W-1:0]     fs;
    } held_t;

    function automatic logic [RATE_W-1:0] rate_hz(input logic [SF_W-1:0] sf);
        logic [RATE_W-1:0] r;
        case (sf)
            4'd1:    r = 18'd8000;
            4'd2:    r = 18'd16000;
            4'd3:    r = 18'd32000;
            4'd6:    r = 18'd11025;
            4'd7:    r = 18'd22050;
            4'd8:    r = 18'd44100;
            4'd11:   r = 18'd12000;
            4'd12:   r = 18'd24000;
            4'd13:   r = 18'd48000;
            4'd14:   r = 18'd96000;
            4'd15:   r = 18'd192000;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic result_t make_valid(input held_t h, input logic le, input logic f14,
                                           input logic [HD_W-1:0] hd);
        result_t r;
        logic [NB_W:0] blocks;
        blocks             = {1'b0, h.nb} + 8'd1;
        r.valid_res        = 1'b1;
        r.little_endian    = le;
        r.fourteen_bit     = f14;
        r.sample_rate      = rate_hz(h.sf);
        r.channel_layout   = h.am;
        r.channel_relation = (h.am == LAYOUT_SUMDIFF) ? REL_SUMDIFF :
                             (h.am == LAYOUT_DOLBY) ? REL_DOLBY : REL_NONE;
        r.lfe_present      = h.lfe;
        r.sample_count     = {blocks, 5'b0};
        r.core_size        = {1'b0, h.fs} + 15'd1;
        r.hd_size          = hd;
        r.total_frame_size = {6'b0, r.core_size} + hd;
        r.spdif_type       = (r.sample_count == CNT_512)  ? SPDIF_512 :
                             (r.sample_count == CNT_1024) ? SPDIF_1024 :
                             (r.sample_count == CNT_2048) ? SPDIF_2048 : SPDIF_NONE;
        return r;
    endfunction

endpackage

### rtl/dtsfh_in_stage.sv
// Input register for the DTS frame header parser: captures one stream word.
// Depends on dtsfh_pkg.
module dtsfh_in_stage (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dtsfh_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic                              s_tuser,   // [0] start_req
    input  logic                              step,
    output logic                              item_valid,
    output dtsfh_pkg::in_item_t               item
);
    import dtsfh_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_tready   = !valid_reg || step;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (step) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.data_byte <= s_tdata[BYTE_W-1:0];
            item_reg.start_req <= s_tuser;
        end
    end

endmodule

### rtl/dtsfh_parse.sv
// Parser state machine: sync detection, header field extraction, extension lookup.
// Depends on dtsfh_pkg.
module dtsfh_parse (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  dtsfh_pkg::in_item_t   item,
    output logic                  emit,
    output dtsfh_pkg::result_t    result
);
    import dtsfh_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WIN_W-1:0]  win_reg, win_next;
    logic [BYTE_W-1:0] pend_reg, pend_next;
    held_t             held_reg, held_next;
    logic              le_reg, le_next;
    logic              f14_reg, f14_next;

    always_comb begin
        phase_t            ph;
        logic [CNT_W-1:0]  n;
        logic [CNT_W-1:0]  e;
        logic [CNT_W-1:0]  core;
        logic [13:0]       k;
        logic [13:0]       ke;
        logic              mode_le;
        logic              mode_14;
        logic              first_ok;
        logic              sync_ok;
        logic [WORD_W-1:0] word;
        logic [WIN_W-1:0]  win_hd;
        logic [WIN_W-1:0]  win_ext;
        logic [NB_W-1:0]   nb;
        logic [FS_W-1:0]   fs;
        logic [5:0]        am;
        logic [SF_W-1:0]   sf;
        logic [1:0]        lff;
        logic [HD_W-1:0]   hd;
        held_t             hf;

        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        win_next   = win_reg;
        pend_next  = pend_reg;
        held_next  = held_reg;
        le_next    = le_reg;
        f14_next   = f14_reg;
        emit       = 1'b0;
        result     = '0;

        ph       = item.start_req ? PH_HEAD : phase_reg;
        n        = item.start_req ? '0 : cnt_reg;
        core     = {1'b0, held_reg.fs} + 15'd1;
        e        = n - core;
        k        = n[CNT_W-1:1];
        ke       = e[CNT_W-1:1];
        mode_le  = le_reg;
        mode_14  = f14_reg;
        first_ok = 1'b1;

        if (ph == PH_HEAD && n == '0) begin
            unique case (item.data_byte)
                FIRST_BE16: begin mode_le = 1'b0; mode_14 = 1'b0; end
                FIRST_LE16: begin mode_le = 1'b1; mode_14 = 1'b0; end
                FIRST_BE14: begin mode_le = 1'b0; mode_14 = 1'b1; end
                FIRST_LE14: begin mode_le = 1'b1; mode_14 = 1'b1; end
                default:    first_ok = 1'b0;
            endcase
        end

        word    = mode_le ? {item.data_byte, pend_reg} : {pend_reg, item.data_byte};
        win_hd  = mode_14 ? {win_reg[WIN_W-15:0], word[13:0]} : {win_reg[WIN_W-17:0], word};
        win_ext = {win_reg[WIN_W-17:0], word};

        if (mode_14) begin
            nb  = win_hd[58:52];
            fs  = win_hd[51:38];
            am  = win_hd[37:32];
            sf  = win_hd[31:28];
            lff = win_hd[12:11];
        end else begin
            nb  = win_hd[56:50];
            fs  = win_hd[49:36];
            am  = win_hd[35:30];
            sf  = win_hd[29:26];
            lff = win_hd[10:9];
        end
        hf.sf  = sf;
        hf.am  = am[LAYOUT_W-1:0];
        hf.lfe = (lff != 2'd0);
        hf.nb  = nb;
        hf.fs  = fs;

        if (k == 14'd0) begin
            sync_ok = word == (mode_14 ? SYNC14_W0 : SYNC16_W0);
        end else if (k == 14'd1) begin
            sync_ok = word == (mode_14 ? SYNC14_W1 : SYNC16_W1);
        end else if (k == 14'd2 && mode_14) begin
            sync_ok = word[15:4] == SYNC14_W2;
        end else begin
            sync_ok = 1'b1;
        end

        hd = win_ext[37] ? {1'b0, win_ext[24:5]} : {5'b0, win_ext[28:13]};
        hd = hd + 21'd1;

        if (step) begin
            if (ph != PH_IDLE) begin
                cnt_next = n + 15'd1;
            end
            unique case (ph)
                PH_IDLE: begin
                end
                PH_HEAD: begin
                    le_next  = mode_le;
                    f14_next = mode_14;
                    if (!first_ok) begin
                        emit       = 1'b1;
                        phase_next = PH_IDLE;
                    end else if (!n[0]) begin
                        pend_next  = item.data_byte;
                        phase_next = PH_HEAD;
                    end else if (!sync_ok) begin
                        emit       = 1'b1;
                        phase_next = PH_IDLE;
                    end else begin
                        win_next   = win_hd;
                        phase_next = PH_HEAD;
                        if (k == (mode_14 ? LAST_WORD14 : LAST_WORD16)) begin
                            if (nb < MIN_BLOCKS || am > MAX_LAYOUT ||
                                rate_hz(sf) == '0 || lff == LFF_BAD) begin
                                emit       = 1'b1;
                                phase_next = PH_IDLE;
                            end else begin
                                held_next = hf;
                                if ({1'b0, fs} < n) begin
                                    emit       = 1'b1;
                                    result     = make_valid(hf, mode_le, mode_14, '0);
                                    phase_next = PH_IDLE;
                                end else begin
                                    phase_next = PH_SKIP;
                                end
                            end
                        end
                    end
                end
                PH_SKIP, PH_EXT: begin
                    if (ph == PH_EXT || n == core) begin
                        phase_next = PH_EXT;
                        if (!e[0]) begin
                            pend_next = item.data_byte;
                        end else if ((ke == 14'd0 && word != EXT_SYNC_W0) ||
                                     (ke == 14'd1 && word != EXT_SYNC_W1)) begin
                            emit       = 1'b1;
                            result     = make_valid(held_reg, le_reg, f14_reg, '0);
                            phase_next = PH_IDLE;
                        end else begin
                            win_next = win_ext;
                            if (ke == EXT_LAST_WORD) begin
                                emit       = 1'b1;
                                result     = make_valid(held_reg, le_reg, f14_reg, hd);
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            le_reg    <= 1'b0;
            f14_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            le_reg    <= le_next;
            f14_reg   <= f14_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg  <= win_next;
        pend_reg <= pend_next;
        held_reg <= held_next;
    end

endmodule

### rtl/dts_frame_header_parser.sv
// DTS core frame header parser, one byte per word on the input stream, with a start
// flag on tuser marking a candidate header; one result word per header, taken from
// an output register so the next byte is accepted while a result waits. Each byte
// passes the input register and is parsed from it, so a byte is accepted every clock
// unless a result waits on a stalled output; a result is registered when the byte that
// completes the header (or its extension lookup) is parsed. Rejected headers report all
// fields zero. Depends on dtsfh_pkg, dtsfh_in_stage and dtsfh_parse.
module dts_frame_header_parser (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dtsfh_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic                              s_tuser,   // [0] start_req
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] little_endian, [1] fourteen_bit, [19:2] sample_rate, [23:20] channel_layout,
    // [25:24] channel_relation, [26] lfe_present, [39:27] sample_count,
    // [54:40] core_size, [75:55] hd_size, [96:76] total_frame_size, [100:97] spdif_type
    output logic [dtsfh_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                              m_tuser    // [0] valid_res
);
    import dtsfh_pkg::*;

    logic     item_valid;
    in_item_t item;
    logic     step;
    logic     emit;
    result_t  result;
    logic     out_valid_reg, out_valid_next;
    result_t  out_reg;

    assign step = item_valid && (!out_valid_reg || m_tready);

    dtsfh_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .step       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    dtsfh_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item),
        .emit    (emit),
        .result  (result)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (step && emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && emit) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.valid_res;
    assign m_tdata  = {3'b0,
                       out_reg.spdif_type,
                       out_reg.total_frame_size,
                       out_reg.hd_size,
                       out_reg.core_size,
                       out_reg.sample_count,
                       out_reg.lfe_present,
                       out_reg.channel_relation,
                       out_reg.channel_layout,
                       out_reg.sample_rate,
                       out_reg.fourteen_bit,
                       out_reg.little_endian};

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for dts_frame_header_parser: streams DTS core headers with
// random content, broken syncs and extension substreams, and scores each result word.
// Depends on dtsfh_pkg and the RTL under rtl/; reads no files.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dtsfh_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_BYTES = 880;

    typedef enum int {
        EXT_NONE,
        EXT_GOOD,
        EXT_HALF,
        EXT_FULL
    } ext_kind_t;

    class dts_header_scoreboard;
        result_t     expected_headers[$];
        int unsigned errors;
        phase_t      ph;
        logic [14:0] byte_idx;
        logic [63:0] window;
        logic [7:0]  first_of_pair;
        logic        le;
        logic        f14;
        logic [3:0]  sf;
        logic [3:0]  am;
        logic        lfe;
        logic [6:0]  nb;
        logic [13:0] fs;

        function new();
            errors        = 0;
            ph            = PH_IDLE;
            byte_idx      = '0;
            window        = '0;
            first_of_pair = '0;
            le            = 1'b0;
            f14           = 1'b0;
            sf            = '0;
            am            = '0;
            lfe           = 1'b0;
            nb            = '0;
            fs            = '0;
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("[%0t] MISMATCH: %s", $realtime, what);
        endtask

        function logic [17:0] rate_of(logic [3:0] code);
            case (code)
                4'd1:    return 18'd8000;
                4'd2:    return 18'd16000;
                4'd3:    return 18'd32000;
                4'd6:    return 18'd11025;
                4'd7:    return 18'd22050;
                4'd8:    return 18'd44100;
                4'd11:   return 18'd12000;
                4'd12:   return 18'd24000;
                4'd13:   return 18'd48000;
                4'd14:   return 18'd96000;
                4'd15:   return 18'd192000;
                default: return 18'd0;
            endcase
        endfunction

        // window holds the newest bits of an MSB-first stream 'total' bits long
        function logic [63:0] window_field(int total, int pos, int width);
            int sh;
            sh = total - pos - width;
            return (window >> sh) & ((64'd1 << width) - 64'd1);
        endfunction

        function bit pair_byte(logic [7:0] b, logic [14:0] idx, output logic [15:0] w);
            w = '0;
            if (!idx[0]) begin
                first_of_pair = b;
                return 1'b0;
            end
            w = le ? {b, first_of_pair} : {first_of_pair, b};
            return 1'b1;
        endfunction

        function void push_rejected();
            result_t r;
            r = '0;
            expected_headers.push_back(r);
            ph = PH_IDLE;
        endfunction

        function void push_header(logic [20:0] hd);
            result_t     r;
            logic [12:0] cnt;
            logic [14:0] core;
            cnt  = ({6'd0, nb} + 13'd1) << 5;
            core = {1'b0, fs} + 15'd1;
            r.valid_res        = 1'b1;
            r.little_endian    = le;
            r.fourteen_bit     = f14;
            r.sample_rate      = rate_of(sf);
            r.channel_layout   = am;
            r.channel_relation = (am == LAYOUT_SUMDIFF) ? REL_SUMDIFF :
                                 (am == LAYOUT_DOLBY) ? REL_DOLBY : REL_NONE;
            r.lfe_present      = lfe;
            r.sample_count     = cnt;
            r.core_size        = core;
            r.hd_size          = hd;
            r.total_frame_size = {6'd0, core} + hd;
            r.spdif_type       = (cnt == CNT_512) ? SPDIF_512 :
                                 (cnt == CNT_1024) ? SPDIF_1024 :
                                 (cnt == CNT_2048) ? SPDIF_2048 : SPDIF_NONE;
            expected_headers.push_back(r);
            ph = PH_IDLE;
        endfunction

        function void parse_header_byte(logic [7:0] b, logic [14:0] n);
            logic [15:0] w;
            logic [14:0] k;
            bit          ok;
            int          total;
            logic [6:0]  f_nb;
            logic [13:0] f_fs;
            logic [5:0]  f_am;
            logic [3:0]  f_sf;
            logic [1:0]  f_lff;
            if (n == 0) begin
                case (b)
                    FIRST_BE16: begin le = 1'b0; f14 = 1'b0; end
                    FIRST_LE16: begin le = 1'b1; f14 = 1'b0; end
                    FIRST_BE14: begin le = 1'b0; f14 = 1'b1; end
                    FIRST_LE14: begin le = 1'b1; f14 = 1'b1; end
                    default: begin
                        push_rejected();
                        return;
                    end
                endcase
                window = '0;
            end
            if (!pair_byte(b, n, w))
                return;
            k  = n >> 1;
            ok = 1'b1;
            if (k == 0)
                ok = (w == (f14 ? SYNC14_W0 : SYNC16_W0));
            else if (k == 1)
                ok = (w == (f14 ? SYNC14_W1 : SYNC16_W1));
            else if (k == 2 && f14)
                ok = (w[15:4] == SYNC14_W2);
            if (!ok) begin
                push_rejected();
                return;
            end
            window = f14 ? {window[49:0], w[13:0]} : {window[47:0], w};
            if (k < (f14 ? LAST_WORD14 : LAST_WORD16))
                return;
            total = f14 ? 98 : 96;
            f_nb  = 7'(window_field(total, 39, 7));
            f_fs  = 14'(window_field(total, 46, 14));
            f_am  = 6'(window_field(total, 60, 6));
            f_sf  = 4'(window_field(total, 66, 4));
            f_lff = 2'(window_field(total, 85, 2));
            if (f_nb < MIN_BLOCKS || f_am > MAX_LAYOUT || rate_of(f_sf) == 0 ||
                f_lff == LFF_BAD) begin
                push_rejected();
                return;
            end
            nb  = f_nb;
            fs  = f_fs;
            am  = f_am[3:0];
            sf  = f_sf;
            lfe = (f_lff != 0);
            if ({1'b0, f_fs} < n)
                push_header('0);
            else
                ph = PH_SKIP;
        endfunction

        function void parse_ext_byte(logic [7:0] b, logic [14:0] e);
            logic [15:0] w;
            logic [14:0] k;
            logic [20:0] hd;
            if (!pair_byte(b, e, w))
                return;
            k = e >> 1;
            if ((k == 0 && w != EXT_SYNC_W0) || (k == 1 && w != EXT_SYNC_W1)) begin
                push_header('0);
                return;
            end
            window = {window[47:0], w};
            if (k < EXT_LAST_WORD)
                return;
            if (window_field(80, 42, 1) != 0)
                hd = 21'(window_field(80, 55, 20)) + 21'd1;
            else
                hd = 21'(window_field(80, 51, 16)) + 21'd1;
            push_header(hd);
        endfunction

        function void note_byte(logic [7:0] b, logic st);
            logic [14:0] n;
            logic [14:0] core;
            if (st) begin
                ph       = PH_HEAD;
                byte_idx = '0;
            end
            if (ph == PH_IDLE)
                return;
            n        = byte_idx;
            byte_idx = byte_idx + 15'd1;
            if (ph == PH_HEAD) begin
                parse_header_byte(b, n);
                return;
            end
            core = {1'b0, fs} + 15'd1;
            if (ph == PH_SKIP) begin
                if (n != core)
                    return;
                ph = PH_EXT;
            end
            parse_ext_byte(b, n - core);
        endfunction

        task cmp_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_result(logic [M_TDATA_W-1:0] d, logic u);
            result_t x;
            if (expected_headers.size() == 0) begin
                report_mismatch("result word with no header pending");
                return;
            end
            x = expected_headers.pop_front();
            cmp_field("valid_res", u, x.valid_res);
            cmp_field("little_endian", d[0], x.little_endian);
            cmp_field("fourteen_bit", d[1], x.fourteen_bit);
            cmp_field("sample_rate", d[19:2], x.sample_rate);
            cmp_field("channel_layout", d[23:20], x.channel_layout);
            cmp_field("channel_relation", d[25:24], x.channel_relation);
            cmp_field("lfe_present", d[26], x.lfe_present);
            cmp_field("sample_count", d[39:27], x.sample_count);
            cmp_field("core_size", d[54:40], x.core_size);
            cmp_field("hd_size", d[75:55], x.hd_size);
            cmp_field("total_frame_size", d[96:76], x.total_frame_size);
            cmp_field("spdif_type", d[100:97], x.spdif_type);
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    dts_header_scoreboard sb = new();
    int                   src_gap_pct    = 12;
    int                   sink_stall_pct = 61;
    int                   quiet_cycles   = 0;
    int                   frame_bytes    = 0;
    logic [7:0]           frame_q[$];

    dts_frame_header_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("dts_frame_header_parser test failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic st);
        while ($urandom_range(0, 99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= st;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    function automatic void put_word(logic [15:0] w, logic le);
        if (le) begin
            frame_q.push_back(w[7:0]);
            frame_q.push_back(w[15:8]);
        end else begin
            frame_q.push_back(w[15:8]);
            frame_q.push_back(w[7:0]);
        end
    endfunction

    // header bits are laid out MSB first: stream position p sits at bits[111-p]
    task automatic send_frame(input logic le, input logic f14, input logic [6:0] nb,
                              input logic [13:0] fs, input logic [5:0] am,
                              input logic [3:0] sf, input logic [1:0] lff,
                              input ext_kind_t ext_kind, input int corrupt_at,
                              input int cut_at);
        logic [111:0] bits;
        logic [15:0]  w;
        int           words;
        int           hdr_len;
        int           core;
        int           k;
        bits = 112'({$urandom, $urandom, $urandom, $urandom});
        bits[72 -: 7]  = nb;
        bits[65 -: 14] = fs;
        bits[51 -: 6]  = am;
        bits[45 -: 4]  = sf;
        bits[26 -: 2]  = lff;
        if (f14)
            bits[111 -: 38] = {SYNC14_W0[13:0], SYNC14_W1[13:0], SYNC14_W2[9:0]};
        else
            bits[111 -: 32] = {SYNC16_W0, SYNC16_W1};
        words = f14 ? 7 : 6;
        for (k = 0; k < words; k++) begin
            if (f14) begin
                w = {2'($urandom), bits[111 - 14 * k -: 14]};
                if (k == 0)
                    w[15:14] = SYNC14_W0[15:14];
                else if (k == 1)
                    w[15:14] = SYNC14_W1[15:14];
                else if (k == 2)
                    w[15:14] = SYNC14_W2[11:10];
            end else begin
                w = bits[111 - 16 * k -: 16];
            end
            put_word(w, le);
        end
        hdr_len = 2 * words;
        core    = int'(fs) + 1;
        if (core >= hdr_len) begin
            repeat (core - hdr_len)
                frame_q.push_back(8'($urandom));
            for (k = 0; k < 5; k++) begin
                w = 16'($urandom);
                if (k == 0 && ext_kind != EXT_NONE)
                    w = EXT_SYNC_W0;
                else if (k == 1 && (ext_kind == EXT_GOOD || ext_kind == EXT_FULL))
                    w = EXT_SYNC_W1;
                else if (k == 1 && ext_kind == EXT_HALF)
                    w = EXT_SYNC_W1 ^ 16'($urandom_range(1, 65535));
                else if (k >= 2 && ext_kind == EXT_FULL)
                    w = '1;
                put_word(w, le);
            end
        end
        if (corrupt_at >= 0 && corrupt_at < frame_q.size())
            frame_q[corrupt_at] = frame_q[corrupt_at] ^ 8'($urandom_range(1, 255));
        if (cut_at >= 0)
            while (frame_q.size() > cut_at)
                void'(frame_q.pop_back());
        for (k = 0; k < frame_q.size(); k++)
            send_byte(frame_q[k], k == 0);
        frame_bytes += frame_q.size();
        frame_q.delete();
    endtask

    task automatic send_random_frame();
        logic        le;
        logic        f14;
        logic [6:0]  nb;
        logic [13:0] fs;
        logic [5:0]  am;
        logic [3:0]  sf;
        logic [1:0]  lff;
        ext_kind_t   ext_kind;
        int          corrupt_at;
        int          cut_at;
        int          r;
        le  = 1'($urandom_range(0, 1));
        f14 = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 5)
            nb = 7'($urandom_range(0, 4));
        else if (r < 30)
            case ($urandom_range(0, 2))
                0:       nb = 7'd15;
                1:       nb = 7'd31;
                default: nb = 7'd63;
            endcase
        else
            nb = 7'($urandom_range(5, 127));
        r = $urandom_range(0, 99);
        if (r < 20)
            fs = 14'($urandom_range(0, 13));
        else if (r < 95)
            fs = 14'($urandom_range(11, 24));
        else
            fs = 14'($urandom_range(25, 300));
        am  = ($urandom_range(0, 99) < 90) ? 6'($urandom_range(0, 9)) :
                                             6'($urandom_range(10, 63));
        lff = ($urandom_range(0, 99) < 90) ? 2'($urandom_range(0, 2)) : 2'd3;
        r = $urandom_range(0, 99);
        sf = 4'($urandom_range(0, 15));
        while (r < 85 && sb.rate_of(sf) == 0)
            sf = 4'($urandom_range(0, 15));
        r = $urandom_range(0, 99);
        ext_kind   = (r < 50) ? EXT_GOOD : (r < 70) ? EXT_HALF : (r < 80) ? EXT_FULL : EXT_NONE;
        corrupt_at = ($urandom_range(0, 99) < 10) ? $urandom_range(0, 13) : -1;
        cut_at     = ($urandom_range(0, 99) < 8) ? $urandom_range(1, 30) : -1;
        send_frame(le, f14, nb, fs, am, sf, lff, ext_kind, corrupt_at, cut_at);
        if ($urandom_range(0, 99) < 25)
            repeat ($urandom_range(1, 4))
                send_byte(8'($urandom), 1'b0);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // well-formed headers in all four sync forms, core boundaries and ext lookups
        send_frame(0, 0, 7'd15, 14'd11, 6'd0, 4'd1, 2'd0, EXT_GOOD, -1, -1);
        send_frame(1, 0, 7'd31, 14'd10, 6'd9, 4'd15, 2'd2, EXT_GOOD, -1, -1);
        send_frame(0, 1, 7'd63, 14'd13, 6'd3, 4'd13, 2'd1, EXT_HALF, -1, -1);
        send_frame(1, 1, 7'd127, 14'd12, 6'd4, 4'd8, 2'd0, EXT_NONE, -1, -1);
        send_frame(0, 0, 7'd5, 14'd0, 6'd2, 4'd3, 2'd0, EXT_GOOD, -1, -1);
        send_frame(1, 1, 7'd20, 14'd20, 6'd7, 4'd6, 2'd1, EXT_FULL, -1, -1);
        // constraint rejects
        send_frame(0, 0, 7'd4, 14'd20, 6'd1, 4'd1, 2'd0, EXT_GOOD, -1, -1);
        send_frame(1, 0, 7'd15, 14'd20, 6'd10, 4'd1, 2'd0, EXT_GOOD, -1, -1);
        send_frame(0, 1, 7'd15, 14'd20, 6'd12, 4'd1, 2'd0, EXT_GOOD, -1, -1);
        send_frame(1, 1, 7'd15, 14'd20, 6'd63, 4'd1, 2'd0, EXT_GOOD, -1, -1);
        send_frame(0, 0, 7'd15, 14'd20, 6'd1, 4'd0, 2'd0, EXT_GOOD, -1, -1);
        send_frame(0, 0, 7'd15, 14'd20, 6'd1, 4'd9, 2'd0, EXT_GOOD, -1, -1);
        send_frame(0, 1, 7'd15, 14'd20, 6'd1, 4'd2, 2'd3, EXT_GOOD, -1, -1);
        // bad first byte, sync mismatches, truncation, bytes while idle
        send_byte(8'h00, 1'b1);
        send_byte(8'h80, 1'b1);
        send_byte(FIRST_BE16, 1'b0);
        send_byte(8'hff, 1'b0);
        send_frame(0, 0, 7'd15, 14'd20, 6'd1, 4'd1, 2'd0, EXT_GOOD, 1, -1);
        send_frame(1, 1, 7'd15, 14'd20, 6'd1, 4'd1, 2'd0, EXT_GOOD, 2, -1);
        send_frame(0, 0, 7'd15, 14'd20, 6'd1, 4'd1, 2'd0, EXT_GOOD, -1, 6);
        send_frame(1, 0, 7'd31, 14'd30, 6'd2, 4'd14, 2'd1, EXT_GOOD, -1, 36);
        // largest extension size
        send_frame(1, 0, 7'd127, 14'd20, 6'd5, 4'd15, 2'd1, EXT_FULL, -1, -1);

        frame_bytes = 0;
        while (frame_bytes < RANDOM_BYTES) begin
            if (frame_bytes >= 2 * RANDOM_BYTES / 3) begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end else if (frame_bytes >= RANDOM_BYTES / 3) begin
                src_gap_pct    = 61;
                sink_stall_pct = 12;
            end
            send_random_frame();
        end
        s_tvalid <= 1'b0;

        while (sb.expected_headers.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.expected_headers.size() != 0)
            sb.report_mismatch("header results never delivered");
        if (sb.errors == 0)
            $display("dts_frame_header_parser test passed");
        else
            $display("dts_frame_header_parser test failed");
        $finish;
    end

endmodule

### dts_frame_header_parser.f
rtl/dtsfh_pkg.sv
rtl/dtsfh_in_stage.sv
rtl/dtsfh_parse.sv
rtl/dts_frame_header_parser.sv
tb/sv/tb_top.sv
